[src/mpeg2_caption_user_data_extractor_top_defines.svh]
// Assertion macros for the caption extractor.
`ifndef MPEG2_CAPTION_USER_DATA_EXTRACTOR_TOP_DEFINES_SVH
`define MPEG2_CAPTION_USER_DATA_EXTRACTOR_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define M2CC_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define M2CC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/m2cc_pkg.sv]
// Shared types, constants and helpers of the caption extractor.
`default_nettype none
package m2cc_pkg;

   localparam int MAX_TRIPLES_DEF = 31;

   typedef struct packed {
      logic [23:0] cc_triple;
      logic        reference_picture;
      logic        last_in_block;
   } entry_type;

   // front -> queue write controls
   typedef struct packed {
      logic      push;
      logic      commit;
      logic      rollback;
      entry_type data;
   } qwr_type;

   // queue -> top status
   typedef struct packed {
      logic full;
      logic busy;
   } qstat_type;

   // room for one full block plus one in progress, rounded to a power of two
   function automatic int queue_depth(input int max_triples);
      return 2 ** $clog2(2 * max_triples);
   endfunction

endpackage
`default_nettype wire

[src/m2cc_if.sv]
// Valid/ready channel interfaces for packet bytes and caption triples.
`default_nettype none
interface m2cc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       first_of_packet;
   logic       last_of_packet;
   logic       pts_valid;

   modport source (output valid, data_byte, first_of_packet, last_of_packet, pts_valid,
                   input ready);
   modport sink   (input valid, data_byte, first_of_packet, last_of_packet, pts_valid,
                   output ready);
endinterface

interface m2cc_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] cc_triple;
   logic        reference_picture;
   logic        last_in_block;

   modport source (output valid, cc_triple, reference_picture, last_in_block,
                   input ready);
   modport sink   (input valid, cc_triple, reference_picture, last_in_block,
                   output ready);
endinterface
`default_nettype wire

[src/m2cc_front.sv]
// Front end: start code scanner, picture type tracking and caption capture.
`default_nettype none
module m2cc_front import m2cc_pkg::*; #(
   parameter int MAX_TRIPLES = MAX_TRIPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       first_of_packet,
   input  logic       last_of_packet,
   input  logic       pts_valid,
   output qwr_type    q_wr
);

   localparam logic [23:0] SC_PREFIX    = 24'h000001;
   localparam logic [7:0]  SC_PICTURE   = 8'h00;
   localparam logic [7:0]  SC_USER_DATA = 8'hB2;
   localparam logic [7:0]  CH_G         = 8'h47;
   localparam logic [7:0]  CH_A         = 8'h41;
   localparam logic [7:0]  CH_9         = 8'h39;
   localparam logic [7:0]  CH_4         = 8'h34;
   localparam logic [7:0]  UD_TYPE_CC   = 8'h03;
   localparam logic [2:0]  PIC_I        = 3'd1;
   localparam logic [2:0]  PIC_P        = 3'd2;

   // header byte offsets after the user-data code
   localparam logic [2:0] HDR_G      = 3'd0;
   localparam logic [2:0] HDR_A      = 3'd1;
   localparam logic [2:0] HDR_9      = 3'd2;
   localparam logic [2:0] HDR_4      = 3'd3;
   localparam logic [2:0] HDR_TYPE   = 3'd4;
   localparam logic [2:0] HDR_FLAGS  = 3'd5;
   localparam logic [2:0] HDR_MARKER = 3'd6;
   localparam logic [2:0] HDR_DATA   = 3'd7;

   logic [31:0] code_shift_ff, code_shift_in;
   logic [2:0]  pic_type_ff, pic_type_in;
   logic        pend_valid_ff [2];
   logic        pend_valid_in [2];
   logic [2:0]  pend_type_ff [2];
   logic [2:0]  pend_type_in [2];
   logic [2:0]  pend_age_ff [2];
   logic [2:0]  pend_age_in [2];
   logic        cap_active_ff, cap_active_in;
   logic [2:0]  hdr_off_ff, hdr_off_in;
   logic [1:0]  part_ff, part_in;
   logic [4:0]  tidx_ff, tidx_in;
   logic [4:0]  count_ff, count_in;
   logic        cap_flag_ff, cap_flag_in;
   logic        ignored_ff, ignored_in;
   logic [15:0] hold_ff, hold_in;

   logic        push, commit, started;
   logic [23:0] wr_triple;
   logic        wr_last;

   always_comb begin
      logic       ok;
      logic       slot;
      logic       e0, e1;
      logic [2:0] eff;

      code_shift_in = code_shift_ff;
      pic_type_in   = pic_type_ff;
      pend_valid_in = pend_valid_ff;
      pend_type_in  = pend_type_ff;
      pend_age_in   = pend_age_ff;
      cap_active_in = cap_active_ff;
      hdr_off_in    = hdr_off_ff;
      part_in       = part_ff;
      tidx_in       = tidx_ff;
      count_in      = count_ff;
      cap_flag_in   = cap_flag_ff;
      ignored_in    = ignored_ff;
      hold_in       = hold_ff;
      push          = 1'b0;
      commit        = 1'b0;
      started       = 1'b0;
      wr_triple     = {hold_ff, data_byte};
      wr_last       = 1'b0;
      ok            = 1'b1;
      slot          = 1'b0;
      e0            = 1'b0;
      e1            = 1'b0;
      eff           = '0;

      if (first_of_packet) begin
         code_shift_in = '1;
         pic_type_in   = '0;
         pend_valid_in = '{1'b0, 1'b0};
         pend_type_in  = '{3'd0, 3'd0};
         pend_age_in   = '{3'd0, 3'd0};
         cap_active_in = 1'b0;
         hdr_off_in    = HDR_G;
         count_in      = '0;
         ignored_in    = ~pts_valid;
      end

      if (!ignored_in) begin
         // age pending picture types; the type byte is the second after the code
         for (int i = 0; i < 2; i++) begin
            if (pend_valid_in[i]) begin
               pend_age_in[i] = pend_age_in[i] + 3'd1;
               if (pend_age_in[i] == 3'd1) pend_type_in[i] = data_byte[5:3];
               if (pend_age_in[i] >= 3'd4) begin
                  pic_type_in      = pend_type_in[i];
                  pend_valid_in[i] = 1'b0;
               end
            end
         end

         if (code_shift_in[31:8] == SC_PREFIX) begin
            if (code_shift_in[7:0] == SC_PICTURE) begin
               if (pend_valid_in[0]) begin
                  if (pend_valid_in[1]) slot = (pend_age_in[0] >= pend_age_in[1]) ? 1'b0 : 1'b1;
                  else                  slot = 1'b1;
               end
               pend_valid_in[slot] = 1'b1;
               pend_age_in[slot]   = '0;
               pend_type_in[slot]  = '0;
            end else if (code_shift_in[7:0] == SC_USER_DATA && !cap_active_in) begin
               // newest picture code seen so far decides, pending or not
               e0 = pend_valid_in[0] && pend_age_in[0] != 3'd0;
               e1 = pend_valid_in[1] && pend_age_in[1] != 3'd0;
               if (e1 && (!e0 || pend_age_in[1] < pend_age_in[0])) eff = pend_type_in[1];
               else if (e0)                                         eff = pend_type_in[0];
               else                                                 eff = pic_type_in;
               cap_flag_in   = (eff == PIC_I) || (eff == PIC_P);
               cap_active_in = 1'b1;
               hdr_off_in    = HDR_G;
               count_in      = '0;
               started       = 1'b1;
            end
         end

         if (cap_active_in) begin
            unique case (hdr_off_in)
               HDR_G:      ok = (data_byte == CH_G);
               HDR_A:      ok = (data_byte == CH_A);
               HDR_9:      ok = (data_byte == CH_9);
               HDR_4:      ok = (data_byte == CH_4);
               HDR_TYPE:   ok = (data_byte == UD_TYPE_CC);
               HDR_FLAGS: begin
                  count_in = data_byte[4:0];
                  ok = data_byte[6] && count_in != 5'd0 && int'(count_in) <= MAX_TRIPLES;
               end
               HDR_MARKER: begin
                  part_in = '0;
                  tidx_in = '0;
               end
               HDR_DATA: begin
                  unique case (part_in)
                     2'd0:    hold_in[15:8] = data_byte;
                     2'd1:    hold_in[7:0]  = data_byte;
                     default: begin
                        push    = 1'b1;
                        wr_last = (tidx_in == count_in - 5'd1);
                        commit  = wr_last;
                     end
                  endcase
               end
               default: ok = 1'b1;
            endcase

            if (!ok) begin
               cap_active_in = 1'b0;
            end else if (commit) begin
               cap_active_in = 1'b0;
            end else if (hdr_off_in != HDR_DATA) begin
               hdr_off_in = hdr_off_in + 3'd1;
            end else if (part_in == 2'd2) begin
               part_in = '0;
               tidx_in = tidx_in + 5'd1;
            end else begin
               part_in = part_in + 2'd1;
            end
         end

         code_shift_in = {code_shift_in[23:0], data_byte};

         if (last_of_packet) begin
            code_shift_in = '1;
            pic_type_in   = '0;
            pend_valid_in = '{1'b0, 1'b0};
            pend_type_in  = '{3'd0, 3'd0};
            pend_age_in   = '{3'd0, 3'd0};
            cap_active_in = 1'b0;
            hdr_off_in    = HDR_G;
            count_in      = '0;
         end
      end
   end

   always_comb begin
      q_wr.push                   = accept && push;
      q_wr.commit                 = accept && commit;
      // a capture that ends unfinished discards its triples
      q_wr.rollback               = accept && !commit && (!cap_active_in || started);
      q_wr.data.cc_triple         = wr_triple;
      q_wr.data.reference_picture = cap_flag_ff;
      q_wr.data.last_in_block     = wr_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_shift_ff <= '1;
         pic_type_ff   <= '0;
         pend_valid_ff <= '{1'b0, 1'b0};
         pend_type_ff  <= '{3'd0, 3'd0};
         pend_age_ff   <= '{3'd0, 3'd0};
         cap_active_ff <= 1'b0;
         hdr_off_ff    <= HDR_G;
         part_ff       <= '0;
         tidx_ff       <= '0;
         count_ff      <= '0;
         cap_flag_ff   <= 1'b0;
         ignored_ff    <= 1'b0;
      end else if (accept) begin
         code_shift_ff <= code_shift_in;
         pic_type_ff   <= pic_type_in;
         pend_valid_ff <= pend_valid_in;
         pend_type_ff  <= pend_type_in;
         pend_age_ff   <= pend_age_in;
         cap_active_ff <= cap_active_in;
         hdr_off_ff    <= hdr_off_in;
         part_ff       <= part_in;
         tidx_ff       <= tidx_in;
         count_ff      <= count_in;
         cap_flag_ff   <= cap_flag_in;
         ignored_ff    <= ignored_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) hold_ff <= hold_in;
   end

endmodule
`default_nettype wire

[src/m2cc_queue.sv]
// Back end: triple queue with commit/rollback and the result output register.
`default_nettype none
module m2cc_queue import m2cc_pkg::*; #(
   parameter int DEPTH = queue_depth(MAX_TRIPLES_DEF)
) (
   input  logic        clock,
   input  logic        reset,
   input  qwr_type     q_wr,
   output qstat_type   q_stat,
   m2cc_rsp_if.source  rsp
);

   localparam int AW = $clog2(DEPTH);
   localparam int PW = AW + 1;

   entry_type mem [DEPTH];

   logic [PW-1:0] spec_ff, spec_in;
   logic [PW-1:0] commit_ff, commit_in;
   logic [PW-1:0] rd_ff, rd_in;
   logic          rd_valid_ff, rd_valid_in;
   entry_type     rd_data_ff;
   logic          out_valid_ff, out_valid_in;
   entry_type     out_data_ff;
   logic          issue, move;

   always_comb begin
      // speculative pointer runs ahead of the committed one during a capture
      spec_in   = spec_ff;
      commit_in = commit_ff;
      if (q_wr.commit) begin
         spec_in   = spec_ff + PW'(1);
         commit_in = spec_ff + PW'(1);
      end else if (q_wr.rollback) begin
         spec_in = commit_ff;
      end else if (q_wr.push) begin
         spec_in = spec_ff + PW'(1);
      end

      move         = rd_valid_ff && (!out_valid_ff || rsp.ready);
      issue        = (rd_ff != commit_ff) && (!rd_valid_ff || move);
      rd_in        = issue ? rd_ff + PW'(1) : rd_ff;
      rd_valid_in  = issue || (rd_valid_ff && !move);
      out_valid_in = move || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         spec_ff      <= '0;
         commit_ff    <= '0;
         rd_ff        <= '0;
         rd_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         spec_ff      <= spec_in;
         commit_ff    <= commit_in;
         rd_ff        <= rd_in;
         rd_valid_ff  <= rd_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_wr.push) mem[spec_ff[AW-1:0]] <= q_wr.data;
      if (issue)     rd_data_ff <= mem[rd_ff[AW-1:0]];
      if (move)      out_data_ff <= rd_data_ff;
   end

   assign q_stat.full = ((spec_ff - rd_ff) == PW'(DEPTH));
   assign q_stat.busy = (rd_ff != commit_ff) || rd_valid_ff || out_valid_ff;

   assign rsp.valid             = out_valid_ff;
   assign rsp.cc_triple         = out_data_ff.cc_triple;
   assign rsp.reference_picture = out_data_ff.reference_picture;
   assign rsp.last_in_block     = out_data_ff.last_in_block;

endmodule
`default_nettype wire

[src/mpeg2_caption_user_data_extractor_top.sv]
// Top level of the MPEG-2 caption user-data extractor.
//
//  channel  | dir | payload                                        | accepted when
//  req_chan | in  | data_byte, first/last_of_packet, pts_valid     | valid && ready
//  rsp_chan | out | cc_triple, reference_picture, last_in_block    | valid && ready
//
// One packet byte per cycle; the front scanner takes a byte every cycle the queue has room.
// Triples of a block become visible once its last byte is taken and leave one per cycle
// while rsp is ready, through the queue read register, then the output register.
// req ready drops only while the triple queue (2**clog2(2*MAX_TRIPLES) entries) is full.
// Synchronous active-high reset; no clearing pass, queue contents need no reset.
`default_nettype none
`include "mpeg2_caption_user_data_extractor_top_defines.svh"
module mpeg2_caption_user_data_extractor_top import m2cc_pkg::*; #(
   parameter int MAX_TRIPLES = MAX_TRIPLES_DEF
) (
   input  logic       clock,
   input  logic       reset,
   m2cc_req_if.sink   req_chan,
   m2cc_rsp_if.source rsp_chan
);

   localparam int QUEUE_DEPTH = queue_depth(MAX_TRIPLES);

   qwr_type   q_wr;
   qstat_type q_stat;
   logic      accept;

   assign req_chan.ready = !q_stat.full;
   assign accept         = req_chan.valid && req_chan.ready;

   m2cc_front #(
      .MAX_TRIPLES (MAX_TRIPLES)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .data_byte       (req_chan.data_byte),
      .first_of_packet (req_chan.first_of_packet),
      .last_of_packet  (req_chan.last_of_packet),
      .pts_valid       (req_chan.pts_valid),
      .q_wr            (q_wr)
   );

   m2cc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_stat (q_stat),
      .rsp    (rsp_chan)
   );

   `M2CC_ASSERT_IMPLIES(a_push_has_room, q_wr.push, !q_stat.full, "triple pushed into full queue")
   `M2CC_ASSERT_IMPLIES(a_push_on_accept, q_wr.push, accept, "triple pushed without a byte")
   `M2CC_ASSERT_NEXT(a_commit_drains, q_wr.commit, q_stat.busy, "committed block not pending")

endmodule
`default_nettype wire

[tb/m2cc_tb_pkg.sv]
// Caption syntax constants shared by the extractor testbench files.
package m2cc_tb_pkg;

   localparam logic [23:0] SC_PREFIX    = 24'h000001;
   localparam logic [7:0]  SC_PICTURE   = 8'h00;
   localparam logic [7:0]  SC_USER_DATA = 8'hB2;
   localparam logic [31:0] ATSC_ID      = "GA94";
   localparam logic [7:0]  CC_TYPE_CODE = 8'h03;
   localparam logic [7:0]  PROCESS_FLAG = 8'h40;
   localparam logic [7:0]  COUNT_MASK   = 8'h1F;
   localparam int          HEADER_LEN   = 7;   // id, type, flags, marker

   localparam logic [2:0] PIC_I = 3'd1;
   localparam logic [2:0] PIC_P = 3'd2;

endpackage

[tb/m2cc_checker.sv]
// Caption extractor checker: predicts triples from accepted bytes and compares them.
module m2cc_caption_checker (
   input  logic  clock,
   input  logic  reset,
   m2cc_req_if   req_chan,
   m2cc_rsp_if   rsp_chan,
   output int    fail_count,
   output int    outstanding,
   output int    triples_checked,
   output int    blocks_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import m2cc_pkg::*;
   import m2cc_tb_pkg::*;

   logic [31:0]  scan_window;
   logic [2:0]   pic_type;
   logic         pend_live [2];
   logic [2:0]   pend_type [2];
   int unsigned  pend_age [2];
   int unsigned  capture_pos;     // 0 idle, else offset after user-data code plus one
   logic [4:0]   block_count;
   logic         block_is_ref;
   logic         skipping_packet;
   logic [23:0]  triple_store [MAX_TRIPLES_DEF];
   entry_type    expected_triples [$];

   function automatic void restart_scanner();
      scan_window = '1;
      pic_type    = '0;
      capture_pos = 0;
      block_count = '0;
      for (int i = 0; i < 2; i++) begin
         pend_live[i] = 1'b0;
         pend_type[i] = '0;
         pend_age[i]  = 0;
      end
   endfunction

   // youngest picture code that has seen its type byte wins over the settled type
   function automatic logic [2:0] type_in_force();
      int best;
      best = -1;
      for (int i = 0; i < 2; i++)
         if (pend_live[i] && pend_age[i] >= 1 && (best < 0 || pend_age[i] < pend_age[best]))
            best = i;
      return (best >= 0) ? pend_type[best] : pic_type;
   endfunction

   task automatic predict_byte(input logic [7:0] b, input logic first_byte,
                               input logic last_byte, input logic pts);
      int unsigned off;
      int unsigned k;
      int unsigned idx;
      int          slot;
      logic        ok;
      logic [2:0]  t;
      entry_type   item;
      if (first_byte) begin
         restart_scanner();
         skipping_packet = !pts;
      end
      if (skipping_packet)
         return;

      for (int i = 0; i < 2; i++) begin
         if (pend_live[i]) begin
            pend_age[i]++;
            if (pend_age[i] == 1)
               pend_type[i] = b[5:3];
            if (pend_age[i] >= 4) begin
               pic_type     = pend_type[i];
               pend_live[i] = 1'b0;
            end
         end
      end

      if (scan_window[31:8] == SC_PREFIX) begin
         if (scan_window[7:0] == SC_PICTURE) begin
            slot = 0;
            if (pend_live[0])
               slot = !pend_live[1] ? 1 : ((pend_age[0] >= pend_age[1]) ? 0 : 1);
            pend_live[slot] = 1'b1;
            pend_age[slot]  = 0;
            pend_type[slot] = '0;
         end else if (scan_window[7:0] == SC_USER_DATA && capture_pos == 0) begin
            t            = type_in_force();
            block_is_ref = (t == PIC_I || t == PIC_P);
            capture_pos  = 1;
            block_count  = '0;
         end
      end

      if (capture_pos != 0) begin
         off = capture_pos - 1;
         ok  = 1'b1;
         if (off < 4)
            ok = (b == ATSC_ID[31 - 8*off -: 8]);
         else if (off == 4)
            ok = (b == CC_TYPE_CODE);
         else if (off == 5) begin
            block_count = 5'(b & COUNT_MASK);
            ok = ((b & PROCESS_FLAG) != 0) && block_count != 0
                 && block_count <= MAX_TRIPLES_DEF;
         end else if (off >= HEADER_LEN) begin
            k   = off - HEADER_LEN;
            idx = k / 3;
            if (idx < MAX_TRIPLES_DEF) begin
               case (k % 3)
                  0: triple_store[idx] = {b, 16'h0000};
                  1: triple_store[idx][15:8] = b;
                  default: triple_store[idx][7:0] = b;
               endcase
            end
         end

         if (!ok)
            capture_pos = 0;
         else if (off >= HEADER_LEN && off == HEADER_LEN - 1 + 3 * block_count) begin
            for (int j = 0; j < block_count; j++) begin
               item.cc_triple         = triple_store[j];
               item.reference_picture = block_is_ref;
               item.last_in_block     = (j + 1 == block_count);
               expected_triples = {expected_triples, item};
            end
            capture_pos = 0;
         end else
            capture_pos++;
      end

      scan_window = {scan_window[23:0], b};
      if (last_byte)
         restart_scanner();
   endtask

   always @(posedge clock) begin
      entry_type seen;
      entry_type want;
      if (reset) begin
         restart_scanner();
         block_is_ref    = 1'b0;
         skipping_packet = 1'b0;
         foreach (triple_store[i])
            triple_store[i] = '0;
         expected_triples.delete();
      end else begin
         if (req_chan.valid && req_chan.ready)
            predict_byte(req_chan.data_byte, req_chan.first_of_packet,
                         req_chan.last_of_packet, req_chan.pts_valid);
         if (rsp_chan.valid && rsp_chan.ready) begin
            seen.cc_triple         = rsp_chan.cc_triple;
            seen.reference_picture = rsp_chan.reference_picture;
            seen.last_in_block     = rsp_chan.last_in_block;
            if (seen.last_in_block === 1'b1)
               blocks_checked++;
            if (expected_triples.size() == 0) begin
               if (fail_count < 10)
                  $display("%t: unexpected triple %h ref=%b last=%b", $realtime,
                           seen.cc_triple, seen.reference_picture, seen.last_in_block);
               fail_count++;
            end else begin
               want = expected_triples.pop_front();
               triples_checked++;
               if (seen !== want) begin
                  if (fail_count < 10)
                     $display("%t: triple expected %h ref=%b last=%b, got %h ref=%b last=%b",
                              $realtime, want.cc_triple, want.reference_picture,
                              want.last_in_block, seen.cc_triple, seen.reference_picture,
                              seen.last_in_block);
                  fail_count++;
               end
            end
         end
      end
      outstanding = expected_triples.size();
   end

endmodule

[tb/tb.sv]
// Top of the caption extractor testbench: clock, reset, packet stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import m2cc_tb_pkg::*;

   localparam int TOTAL_BYTES  = 450;
   localparam int PRESSURE_AT  = 100;
   localparam int HOLD_CYCLES  = 1000;
   localparam int IDLE_LIMIT   = 5000;
   localparam int DRAIN_CYCLES = 20;

   typedef struct {
      logic [7:0] data;
      logic       first_byte;
      logic       last_byte;
      logic       pts;
   } packet_byte_type;

   logic clock;
   logic reset;

   m2cc_req_if req_chan ();
   m2cc_rsp_if rsp_chan ();

   int fail_count;
   int outstanding;
   int triples_checked;
   int blocks_checked;

   packet_byte_type packet_q [$];
   int burst_left;
   int scanned_bytes;
   int untimed_bytes;
   int packets_sent;
   int idle_cycles;
   bit skipping;
   bit hold_request;

   mpeg2_caption_user_data_extractor_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   m2cc_caption_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_chan        (req_chan),
      .rsp_chan        (rsp_chan),
      .fail_count      (fail_count),
      .outstanding     (outstanding),
      .triples_checked (triples_checked),
      .blocks_checked  (blocks_checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles = 0;
      else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles, %0d triples outstanding",
                     IDLE_LIMIT, outstanding);
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // result side: random stall modes, plus one long hold-off on request
   initial begin
      int mode;
      int mode_left;
      int phase;
      mode_left = 0;
      phase = 0;
      rsp_chan.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            if (mode_left == 0) begin
               mode = $urandom_range(0, 3);
               mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            phase++;
            case (mode)
               0: rsp_chan.ready <= 1'b1;
               1: rsp_chan.ready <= 1'($urandom_range(0, 1));
               2: rsp_chan.ready <= (phase % 3 != 0);
               default: rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   function automatic void put_byte(input logic [7:0] b);
      packet_byte_type pb;
      pb.data       = b;
      pb.first_byte = 1'b0;
      pb.last_byte  = 1'b0;
      pb.pts        = 1'($urandom_range(0, 1));
      packet_q = {packet_q, pb};
   endfunction

   function automatic void put_start_code(input logic [7:0] code);
      put_byte(SC_PREFIX[23:16]);
      put_byte(SC_PREFIX[15:8]);
      put_byte(SC_PREFIX[7:0]);
      put_byte(code);
   endfunction

   function automatic void put_picture_header();
      put_start_code(SC_PICTURE);
      put_byte(8'($urandom));
      put_byte({2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7))});
   endfunction

   // flaw: 0 clean, 1 bad id letter, 2 bad type byte, 3 no process flag, 4 zero count
   function automatic void put_caption_block(input int n, input int flaw);
      logic [7:0] letter;
      logic [7:0] flags;
      int bad_pos;
      int j;
      bad_pos = $urandom_range(0, 3);
      put_start_code(SC_USER_DATA);
      for (int i = 0; i < 4; i++) begin
         letter = ATSC_ID[31 - 8*i -: 8];
         if (flaw == 1 && i == bad_pos)
            letter ^= 8'($urandom_range(1, 255));
         put_byte(letter);
      end
      put_byte((flaw == 2) ? (CC_TYPE_CODE ^ 8'($urandom_range(1, 255))) : CC_TYPE_CODE);
      flags = {1'($urandom_range(0, 1)), 1'b1, 1'($urandom_range(0, 1)), 5'(n)};
      if (flaw == 3)
         flags = flags & ~PROCESS_FLAG;
      if (flaw == 4)
         flags = flags & ~COUNT_MASK;
      put_byte(flags);
      put_byte(8'($urandom));
      j = 0;
      // a start code buried in the triples must not open a new block
      if (3 * n >= 4 && $urandom_range(0, 5) == 0) begin
         put_start_code($urandom_range(0, 1) ? SC_USER_DATA : SC_PICTURE);
         j = 4;
      end
      while (j < 3 * n) begin
         put_byte(8'($urandom));
         j++;
      end
   endfunction

   task automatic send_packet(input logic pts, input bit mark_first, input bit mark_last,
                              input bit cut);
      int keep;
      if (cut && packet_q.size() > 1) begin
         keep = $urandom_range(1, packet_q.size() - 1);
         packet_q = packet_q[0:keep-1];
      end
      if (mark_first) begin
         packet_q[0].first_byte = 1'b1;
         packet_q[0].pts = pts;
      end
      if (mark_last)
         packet_q[packet_q.size() - 1].last_byte = 1'b1;
      foreach (packet_q[i]) begin
         @(negedge clock);
         if (burst_left == 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 200)
                                                       : $urandom_range(1, 24);
         end
         req_chan.valid           <= 1'b1;
         req_chan.data_byte       <= packet_q[i].data;
         req_chan.first_of_packet <= packet_q[i].first_byte;
         req_chan.last_of_packet  <= packet_q[i].last_byte;
         req_chan.pts_valid       <= packet_q[i].pts;
         @(posedge clock);
         while (!req_chan.ready)
            @(posedge clock);
         burst_left--;
         if (packet_q[i].first_byte)
            skipping = !packet_q[i].pts;
         if (skipping)
            untimed_bytes++;
         else
            scanned_bytes++;
      end
      packet_q.delete();
      packets_sent++;
   endtask

   initial begin
      int kind;
      int n;
      bit pressure_done;
      pressure_done = 1'b0;
      burst_left = 0;
      req_chan.valid           = 1'b0;
      req_chan.data_byte       = '0;
      req_chan.first_of_packet = 1'b0;
      req_chan.last_of_packet  = 1'b0;
      req_chan.pts_valid       = 1'b0;
      reset = 1'b1;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // bytes ahead of any packet start: I picture, then a one-triple block
      put_start_code(SC_PICTURE);
      put_byte(8'h5A);
      put_byte({2'b00, PIC_I, 3'b000});
      put_start_code(SC_USER_DATA);
      for (int i = 0; i < 4; i++)
         put_byte(ATSC_ID[31 - 8*i -: 8]);
      put_byte(CC_TYPE_CODE);
      put_byte(8'h80 | PROCESS_FLAG | 8'h01);
      put_byte(8'hFF);
      put_byte(8'h00);
      put_byte(8'hFF);
      put_byte(8'h80);
      send_packet(1'b1, 1'b0, 1'b1, 1'b0);
      // a complete block inside a packet without timestamp yields nothing
      put_caption_block(1, 0);
      send_packet(1'b0, 1'b1, 1'b1, 1'b0);
      // one-byte packet: first and last on the same item
      put_byte(8'hFF);
      send_packet(1'b1, 1'b1, 1'b1, 1'b0);

      while (scanned_bytes + untimed_bytes < TOTAL_BYTES) begin
         if (!pressure_done && scanned_bytes + untimed_bytes >= PRESSURE_AT) begin
            // more triples than the queue holds while the output is held off
            put_picture_header();
            put_caption_block(31, 0);
            put_caption_block(31, 0);
            put_caption_block(15, 0);
            hold_request = 1'b1;
            send_packet(1'b1, 1'b1, 1'b1, 1'b0);
            pressure_done = 1'b1;
         end
         repeat ($urandom_range(1, 4)) begin
            kind = $urandom_range(0, 99);
            if (kind < 45) begin
               n = ($urandom_range(0, 19) == 0) ? 31
                 : (($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(1, 4));
               put_caption_block(n, 0);
            end else if (kind < 70)
               put_picture_header();
            else if (kind < 82)
               put_caption_block($urandom_range(1, 4), $urandom_range(1, 4));
            else
               repeat ($urandom_range(1, 6))
                  put_byte(($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, 1))
                                                       : 8'($urandom));
         end
         send_packet(1'($urandom_range(0, 7) != 0), $urandom_range(0, 11) != 0,
                     $urandom_range(0, 11) != 0, $urandom_range(0, 5) == 0);
      end

      @(negedge clock);
      req_chan.valid <= 1'b0;
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d packets: %0d bytes scanned, %0d bytes in untimed packets,",
               packets_sent, scanned_bytes, untimed_bytes);
      $display("  one long output hold-off; %0d triples checked in %0d blocks",
               triples_checked, blocks_checked);
      if (fail_count == 0 && outstanding == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
